/* rtl/bnes_pkg.sv */
// Shared types and constants for the breath note event sequencer.
// No dependencies; imported by breath_note_event_sequencer_top.
package bnes_pkg;

    typedef enum logic [1:0] {
        OP_PRESS = 2'd0,
        OP_NOTE  = 2'd1,
        OP_BEND  = 2'd2,
        OP_EXPR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MSG_BEND   = 3'd0,
        MSG_EXPR   = 3'd1,
        MSG_ON     = 3'd2,
        MSG_OFF    = 3'd3,
        MSG_CHANGE = 3'd4
    } t_msg;

    localparam logic       CFG_EXTERNAL = 1'b0;
    localparam logic       CFG_VELOCITY = 1'b1;

    localparam logic [13:0] BEND_MAX = 14'd8192;
    localparam logic [6:0]  MIDI_MAX = 7'd127;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        to_external;
        t_msg        message;
        logic [13:0] data;
        logic [6:0]  velocity;
        logic        last;
    } t_entry;

endpackage

/* rtl/breath_note_event_sequencer_top.sv */
// Top level of the breath note event sequencer: event decode, player state
// and a four-beat result queue. Depends on bnes_pkg.
//
// Order: the beats of an accepted event are written to the result queue
//   together and offered behind any beats already queued, one a cycle while
//   i_out_stall is low. Throughput: one event per cycle while the queue holds
//   at most one beat; beyond that the event side stalls until beats drain.
// Reset (i_rst_n low, synchronous): idle, nothing known, queue empty,
//   external_output 0 and note_velocity 127.
module breath_note_event_sequencer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // event channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic              i_pressure_on,
    input  logic signed [15:0] i_value,
    // message channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_to_external,
    output logic [2:0]        o_message,
    output logic [13:0]       o_data,
    output logic [6:0]        o_velocity,
    output logic              o_last,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [6:0]        i_cfg_data
);
    import bnes_pkg::*;

    // Configuration registers.
    logic        r_external;
    logic [6:0]  r_velocity;

    // Player state.
    logic        r_playing,   n_playing;
    logic [6:0]  r_note,      n_note;
    logic        r_note_kn,   n_note_kn;
    logic [13:0] r_bend,      n_bend;
    logic        r_bend_kn,   n_bend_kn;
    logic [6:0]  r_expr,      n_expr;
    logic        r_expr_kn,   n_expr_kn;
    logic [6:0]  r_sounding,  n_sounding;
    logic [13:0] r_sent_bend, n_sent_bend;
    logic [6:0]  r_sent_expr, n_sent_expr;

    // Result queue. Each event writes up to three beats at once.
    t_entry           r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic   in_acc;
    logic   out_pop;
    t_entry slot0, slot1, slot2;
    logic [1:0] push_n;

    logic [6:0]  cl_note;
    logic [13:0] cl_bend;
    logic [6:0]  cl_expr;
    logic [6:0]  vel_ext;
    logic [13:0] press_bend;
    logic [6:0]  press_expr;

    function automatic logic [6:0] clamp7(input logic signed [15:0] v);
        if (v < 16'sd0) begin
            return 7'd0;
        end else if (v > 16'sd127) begin
            return MIDI_MAX;
        end
        return v[6:0];
    endfunction

    function automatic logic [13:0] clamp14(input logic signed [15:0] v);
        if (v < 16'sd0) begin
            return 14'd0;
        end else if (v > 16'sd8192) begin
            return BEND_MAX;
        end
        return v[13:0];
    endfunction

    function automatic t_entry mk(input logic ext, input t_msg msg,
                                  input logic [13:0] data, input logic [6:0] vel);
        t_entry e;
        e.to_external = ext;
        e.message     = msg;
        e.data        = data;
        e.velocity    = vel;
        e.last        = 1'b0;
        return e;
    endfunction

    // The event side only looks at the fill level, so its stall never
    // depends on the message side in the same cycle. One or fewer beats
    // queued leaves room for a full three-beat event.
    assign o_in_stall  = (r_count > CNT_W'(FIFO_DEPTH - 3));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = (r_count != '0);
    assign out_pop     = o_out_valid && !i_out_stall;

    assign o_to_external = r_fifo[r_rd_ptr].to_external;
    assign o_message     = r_fifo[r_rd_ptr].message;
    assign o_data        = r_fifo[r_rd_ptr].data;
    assign o_velocity    = r_fifo[r_rd_ptr].velocity;
    assign o_last        = r_fifo[r_rd_ptr].last;

    assign cl_note    = clamp7(i_value);
    assign cl_bend    = clamp14(i_value);
    assign cl_expr    = clamp7(i_value);
    assign vel_ext    = r_external ? r_velocity : 7'd0;
    assign press_bend = r_bend_kn ? r_bend : BEND_MAX;
    assign press_expr = r_expr_kn ? r_expr : MIDI_MAX;

    // Event decode: next player state and the beats this event produces.
    // Nothing changes unless the event beat is actually accepted.
    always_comb begin
        n_playing   = r_playing;
        n_note      = r_note;
        n_note_kn   = r_note_kn;
        n_bend      = r_bend;
        n_bend_kn   = r_bend_kn;
        n_expr      = r_expr;
        n_expr_kn   = r_expr_kn;
        n_sounding  = r_sounding;
        n_sent_bend = r_sent_bend;
        n_sent_expr = r_sent_expr;
        slot0       = mk(r_external, MSG_BEND, 14'd0, 7'd0);
        slot1       = slot0;
        slot2       = slot0;
        push_n      = 2'd0;

        if (in_acc) begin
            case (t_op'(i_operation))
                OP_PRESS: begin
                    if (!r_playing) begin
                        if (i_pressure_on && r_note_kn) begin
                            // A press fills in defaults for anything never set.
                            n_bend      = press_bend;
                            n_bend_kn   = 1'b1;
                            n_expr      = press_expr;
                            n_expr_kn   = 1'b1;
                            n_sounding  = r_note;
                            n_sent_bend = press_bend;
                            n_sent_expr = press_expr;
                            n_playing   = 1'b1;
                            slot0 = mk(r_external, MSG_BEND, press_bend, 7'd0);
                            if (r_external) begin
                                slot1  = mk(r_external, MSG_EXPR, {7'd0, press_expr}, 7'd0);
                                slot2  = mk(r_external, MSG_ON, {7'd0, r_note}, vel_ext);
                                push_n = 2'd3;
                            end else begin
                                slot1  = mk(r_external, MSG_ON, {7'd0, r_note}, vel_ext);
                                push_n = 2'd2;
                            end
                        end
                    end else if (!i_pressure_on) begin
                        slot0     = mk(r_external, MSG_OFF, {7'd0, r_sounding}, vel_ext);
                        push_n    = 2'd1;
                        n_playing = 1'b0;
                    end
                end
                OP_NOTE: begin
                    n_note    = cl_note;
                    n_note_kn = 1'b1;
                    if (r_playing && (cl_note != r_sounding)) begin
                        n_sounding = cl_note;
                        if (r_external) begin
                            // The external device gets an explicit off/on pair.
                            slot0  = mk(r_external, MSG_OFF, {7'd0, r_sounding}, r_velocity);
                            slot1  = mk(r_external, MSG_ON, {7'd0, cl_note}, r_velocity);
                            push_n = 2'd2;
                        end else begin
                            slot0  = mk(r_external, MSG_CHANGE, {7'd0, cl_note}, 7'd0);
                            push_n = 2'd1;
                        end
                    end
                end
                OP_BEND: begin
                    n_bend    = cl_bend;
                    n_bend_kn = 1'b1;
                    if (r_playing && (cl_bend != r_sent_bend)) begin
                        n_sent_bend = cl_bend;
                        slot0       = mk(r_external, MSG_BEND, cl_bend, 7'd0);
                        push_n      = 2'd1;
                    end
                end
                OP_EXPR: begin
                    n_expr    = cl_expr;
                    n_expr_kn = 1'b1;
                    if (r_playing && (cl_expr != r_sent_expr)) begin
                        // The internal synth tracks the value without a message.
                        n_sent_expr = cl_expr;
                        if (r_external) begin
                            slot0  = mk(r_external, MSG_EXPR, {7'd0, cl_expr}, 7'd0);
                            push_n = 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Mark the final beat of this event.
        case (push_n)
            2'd1:    slot0.last = 1'b1;
            2'd2:    slot1.last = 1'b1;
            2'd3:    slot2.last = 1'b1;
            default: begin
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_external  <= 1'b0;
            r_velocity  <= MIDI_MAX;
            r_playing   <= 1'b0;
            r_note      <= '0;
            r_note_kn   <= 1'b0;
            r_bend      <= '0;
            r_bend_kn   <= 1'b0;
            r_expr      <= '0;
            r_expr_kn   <= 1'b0;
            r_sounding  <= '0;
            r_sent_bend <= '0;
            r_sent_expr <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EXTERNAL: r_external <= i_cfg_data[0];
                    CFG_VELOCITY: r_velocity <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_playing   <= n_playing;
            r_note      <= n_note;
            r_note_kn   <= n_note_kn;
            r_bend      <= n_bend;
            r_bend_kn   <= n_bend_kn;
            r_expr      <= n_expr;
            r_expr_kn   <= n_expr_kn;
            r_sounding  <= n_sounding;
            r_sent_bend <= n_sent_bend;
            r_sent_expr <= n_sent_expr;
            r_wr_ptr    <= r_wr_ptr + PTR_W'(push_n);
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push_n) - CNT_W'(out_pop);
        end
    end

    // Queue payload; written only for the beats this event produces.
    always_ff @(posedge i_clk) begin
        if (push_n >= 2'd1) begin
            r_fifo[r_wr_ptr] <= slot0;
        end
        if (push_n >= 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= slot1;
        end
        if (push_n == 2'd3) begin
            r_fifo[r_wr_ptr + PTR_W'(2)] <= slot2;
        end
    end

    // The queue never holds more beats than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // Playing only starts from an accepted press event.
    a_play_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_playing) |-> $past(in_acc && (i_operation == OP_PRESS) && i_pressure_on))
        else $error("playing started without a press");

    // A beat offered with a note or expression message carries a MIDI data value.
    a_data_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_message != MSG_BEND)) |-> (o_data <= 14'd127))
        else $error("note or expression data out of range");

    // A note change message only goes to the internal synth and ends its event.
    a_change_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_message == MSG_CHANGE)) |-> (!o_to_external && o_last))
        else $error("note change routed externally or not final");

endmodule
